### src/fsp_pkg.sv
// fsp_pkg: shared types, character codes and helper functions for the
// format specifier parser. No dependencies.
package fsp_pkg;

  // accumulator width for width and precision values
  localparam int ACC_W = 16;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // parser phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FLAGS = 2'd1;
  localparam logic [1:0] PH_WIDTH = 2'd2;
  localparam logic [1:0] PH_PREC  = 2'd3;

  // character codes
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // flag bit positions
  localparam int FL_HASH  = 0;
  localparam int FL_ZERO  = 1;
  localparam int FL_DASH  = 2;
  localparam int FL_PLUS  = 3;
  localparam int FL_SPACE = 4;

  typedef struct packed {
    logic [7:0]       ch;
    logic [ACC_W-1:0] text_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       conv_char;
    logic             conv_known;
    logic             alt_form;
    logic             zero_pad;
    logic             left_align;
    logic             plus_sign;
    logic             space_sign;
    logic             has_precision;
    logic [ACC_W-1:0] field_width;
    logic [ACC_W-1:0] precision_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [4:0]       flag_bits;
    logic [7:0]       last_flag;
    logic [ACC_W-1:0] width_acc;
    logic [ACC_W-1:0] prec_acc;
    logic             dot_seen;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:     PH_IDLE,
    flag_bits: 5'd0,
    last_flag: 8'd0,
    width_acc: '0,
    prec_acc:  '0,
    dot_seen:  1'b0
  };

  // conversion characters c s p d i u x X %
  function automatic logic is_conv(input logic [7:0] c);
    return (c == CH_C) || (c == CH_S) || (c == CH_P) || (c == CH_D) ||
           (c == CH_I) || (c == CH_U) || (c == CH_LX) || (c == CH_UX) ||
           (c == CH_PCT);
  endfunction

  // one-hot flag mask, zero for a non-flag character
  function automatic logic [4:0] flag_mask(input logic [7:0] c);
    logic [4:0] m;
    m = 5'd0;
    m[FL_HASH]  = (c == CH_HASH);
    m[FL_ZERO]  = (c == CH_ZERO);
    m[FL_DASH]  = (c == CH_DASH);
    m[FL_PLUS]  = (c == CH_PLUS);
    m[FL_SPACE] = (c == CH_SPACE);
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc * 10 + digit, saturating at the accumulator maximum
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [7:0] c);
    logic [ACC_W+3:0] wide;
    logic [ACC_W+3:0] sum;
    wide = {4'd0, acc};
    sum  = (wide << 3) + (wide << 1) + {{ACC_W{1'b0}}, c[3:0]};
    if (sum > {4'd0, ACC_MAX}) begin
      return ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

### src/fsp_step.sv
// fsp_step: per-character phase and accumulator update of the parser.
// Depends on fsp_pkg.
module fsp_step (
  input  fsp_pkg::parse_state_t cur,
  input  logic [7:0]            ch,
  output fsp_pkg::parse_state_t nxt,
  output logic                  emit
);

  logic [4:0] mask;
  logic       is_flag;
  logic       flag_free;
  logic       nonzero_digit;

  // character classes
  assign mask          = fsp_pkg::flag_mask(ch);
  assign is_flag       = |mask;
  assign flag_free     = ((cur.flag_bits & mask) == 5'd0);
  assign nonzero_digit = (ch >= fsp_pkg::CH_ONE) && (ch <= fsp_pkg::CH_NINE);

  // phase transitions
  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    unique case (cur.phase)
      fsp_pkg::PH_IDLE: begin
        if (ch == fsp_pkg::CH_PCT) begin
          nxt       = fsp_pkg::STATE_CLEAR;
          nxt.phase = fsp_pkg::PH_FLAGS;
        end
      end
      fsp_pkg::PH_FLAGS: begin
        priority if (fsp_pkg::is_conv(ch)) begin
          emit = 1'b1;
        end else if (is_flag && ch == cur.last_flag) begin
          // run of the same flag is swallowed
        end else if (is_flag && flag_free) begin
          nxt.flag_bits = cur.flag_bits | mask;
          nxt.last_flag = ch;
        end else if (nonzero_digit) begin
          nxt.width_acc = fsp_pkg::acc_digit('0, ch);
          nxt.phase     = fsp_pkg::PH_WIDTH;
        end else if (ch == fsp_pkg::CH_DOT) begin
          nxt.dot_seen = 1'b1;
          nxt.phase    = fsp_pkg::PH_PREC;
        end else begin
          emit = 1'b1;
        end
      end
      fsp_pkg::PH_WIDTH: begin
        priority if (fsp_pkg::is_digit(ch)) begin
          nxt.width_acc = fsp_pkg::acc_digit(cur.width_acc, ch);
        end else if (ch == fsp_pkg::CH_DOT) begin
          nxt.dot_seen = 1'b1;
          nxt.phase    = fsp_pkg::PH_PREC;
        end else begin
          emit = 1'b1;
        end
      end
      fsp_pkg::PH_PREC: begin
        if (fsp_pkg::is_digit(ch)) begin
          nxt.prec_acc = fsp_pkg::acc_digit(cur.prec_acc, ch);
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        nxt = fsp_pkg::STATE_CLEAR;
      end
    endcase
    // a finished specifier leaves the parser clear
    if (emit) begin
      nxt = fsp_pkg::STATE_CLEAR;
    end
  end

endmodule

### src/fsp_resolve.sv
// fsp_resolve: applies the flag conflict rules and builds the result request.
// Depends on fsp_pkg.
module fsp_resolve (
  input  fsp_pkg::parse_state_t cur,
  input  fsp_pkg::in_item_t     item,
  output fsp_pkg::out_item_t    res
);

  logic c_is_c, c_is_s, c_is_p, c_signed, c_hex;
  logic hash, zero, dash, plus, space, dot;

  assign c_is_c   = (item.ch == fsp_pkg::CH_C);
  assign c_is_s   = (item.ch == fsp_pkg::CH_S);
  assign c_is_p   = (item.ch == fsp_pkg::CH_P);
  assign c_signed = (item.ch == fsp_pkg::CH_D) || (item.ch == fsp_pkg::CH_I);
  assign c_hex    = (item.ch == fsp_pkg::CH_LX) || (item.ch == fsp_pkg::CH_UX);

  // conflict rules in order
  always_comb begin
    hash  = cur.flag_bits[fsp_pkg::FL_HASH];
    zero  = cur.flag_bits[fsp_pkg::FL_ZERO];
    dash  = cur.flag_bits[fsp_pkg::FL_DASH];
    plus  = cur.flag_bits[fsp_pkg::FL_PLUS];
    space = cur.flag_bits[fsp_pkg::FL_SPACE];
    dot   = cur.dot_seen;
    if (dash) begin
      zero = 1'b0;
    end
    if (plus) begin
      space = 1'b0;
    end
    if (!c_signed) begin
      plus  = 1'b0;
      space = 1'b0;
    end
    if (!c_hex) begin
      hash = 1'b0;
    end
    if (c_is_c || c_is_p) begin
      dot = 1'b0;
    end
    if (c_is_c || c_is_p || c_is_s) begin
      zero = 1'b0;
    end
    if (dot && (item.text_length > cur.prec_acc)) begin
      zero = 1'b0;
    end
  end

  // result fields
  always_comb begin
    res.conv_char       = item.ch;
    res.conv_known      = fsp_pkg::is_conv(item.ch);
    res.alt_form        = hash;
    res.zero_pad        = zero;
    res.left_align      = dash;
    res.plus_sign       = plus;
    res.space_sign      = space;
    res.has_precision   = dot;
    res.field_width     = cur.width_acc;
    res.precision_value = cur.prec_acc;
  end

endmodule

### src/format_spec_parser_unit.sv
// format_spec_parser_unit: printf-style format specifier parser, top level.
// A character is accepted into the input register and parsed there; its result is registered in the output register.
// Throughput: one character per cycle; the input register stalls only while
// the output register holds a result that out_stall keeps.
// Reset (rst_n low, synchronous): parser idle waiting for '%', both
// pipeline registers empty. Depends on fsp_pkg, fsp_step, fsp_resolve.
module format_spec_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_item_t out_data
);

  logic                  s1_valid_r, s1_valid_nxt;
  fsp_pkg::in_item_t     s1_data_r;
  fsp_pkg::parse_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fsp_pkg::out_item_t    out_data_r;

  logic                  out_load;
  logic                  advance;
  logic                  emit;
  fsp_pkg::out_item_t    res;

  // pipeline flow control
  assign out_load = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;

  fsp_step u_step (
    .cur  (state_r),
    .ch   (s1_data_r.ch),
    .nxt  (state_nxt),
    .emit (emit)
  );

  fsp_resolve u_resolve (
    .cur  (state_r),
    .item (s1_data_r),
    .res  (res)
  );

  // next values of the valid flags
  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = out_load ? (advance && emit) : out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= fsp_pkg::STATE_CLEAR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input register holds its character while the output side is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register lost its character while blocked");

  // a finished specifier returns the parser to idle
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> (state_r.phase == fsp_pkg::PH_IDLE &&
                           state_r.flag_bits == 5'd0 && !state_r.dot_seen))
    else $error("parser state not cleared after a result");

  // a taken result with nothing behind it empties the output register
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(advance && emit)) |=> !out_valid_r)
    else $error("result repeated on the output");

  // precision is never kept for c or p
  a_prec_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.has_precision) |->
      (out_data_r.conv_char != fsp_pkg::CH_C && out_data_r.conv_char != fsp_pkg::CH_P))
    else $error("precision kept for c or p conversion");

endmodule

### dv/format_spec_parser_unit_tb.sv
`timescale 1ns / 1ps
// format_spec_parser_unit_tb: self-checking bench for the format specifier parser.
// Feeds directed and random format strings and checks each resolved specifier
// against a parse model built into spec_checker. Depends on fsp_pkg and the RTL top.

// parse model plus the store of specifiers still due from the block
class spec_checker;
  localparam int NO_FLAG = 5;

  logic [1:0]                phase;
  logic [4:0]                flags;
  logic [7:0]                last_flag;
  logic [fsp_pkg::ACC_W-1:0] width_acc;
  logic [fsp_pkg::ACC_W-1:0] prec_acc;
  logic                      dot_seen;
  fsp_pkg::out_item_t        expected_specs[$];
  int                        errors;

  function new();
    clear_parse();
    errors = 0;
  endfunction

  function void clear_parse();
    phase     = fsp_pkg::PH_IDLE;
    flags     = '0;
    last_flag = '0;
    width_acc = '0;
    prec_acc  = '0;
    dot_seen  = 1'b0;
  endfunction

  function bit conv_known(input logic [7:0] c);
    case (c)
      fsp_pkg::CH_C, fsp_pkg::CH_S, fsp_pkg::CH_P, fsp_pkg::CH_D, fsp_pkg::CH_I,
      fsp_pkg::CH_U, fsp_pkg::CH_LX, fsp_pkg::CH_UX, fsp_pkg::CH_PCT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function int flag_slot(input logic [7:0] c);
    case (c)
      fsp_pkg::CH_HASH:  return fsp_pkg::FL_HASH;
      fsp_pkg::CH_ZERO:  return fsp_pkg::FL_ZERO;
      fsp_pkg::CH_DASH:  return fsp_pkg::FL_DASH;
      fsp_pkg::CH_PLUS:  return fsp_pkg::FL_PLUS;
      fsp_pkg::CH_SPACE: return fsp_pkg::FL_SPACE;
      default:           return NO_FLAG;
    endcase
  endfunction

  function bit is_num(input logic [7:0] c);
    return (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
  endfunction

  // decimal shift-in with saturation
  function logic [fsp_pkg::ACC_W-1:0] push_digit(input logic [fsp_pkg::ACC_W-1:0] acc,
                                                 input logic [7:0] c);
    longint unsigned n;
    n = 64'(acc);
    n = n * 10 + 64'(c[3:0]);
    if (n > 64'(fsp_pkg::ACC_MAX)) return fsp_pkg::ACC_MAX;
    return n[fsp_pkg::ACC_W-1:0];
  endfunction

  // apply the conflict rules and queue the resolved specifier
  function void close_spec(input logic [7:0] c, input logic [fsp_pkg::ACC_W-1:0] len);
    fsp_pkg::out_item_t e;
    logic hash, zero, dash, plus, space, dot;
    hash  = flags[fsp_pkg::FL_HASH];
    zero  = flags[fsp_pkg::FL_ZERO];
    dash  = flags[fsp_pkg::FL_DASH];
    plus  = flags[fsp_pkg::FL_PLUS];
    space = flags[fsp_pkg::FL_SPACE];
    dot   = dot_seen;
    if (zero && dash) zero = 1'b0;
    if (plus && space) space = 1'b0;
    if (c != fsp_pkg::CH_I && c != fsp_pkg::CH_D) begin
      space = 1'b0;
      plus  = 1'b0;
    end
    if (c != fsp_pkg::CH_LX && c != fsp_pkg::CH_UX) hash = 1'b0;
    if (c == fsp_pkg::CH_C || c == fsp_pkg::CH_P) dot = 1'b0;
    if (c == fsp_pkg::CH_C || c == fsp_pkg::CH_P || c == fsp_pkg::CH_S) zero = 1'b0;
    if (dot && len > prec_acc) zero = 1'b0;
    e.conv_char       = c;
    e.conv_known      = conv_known(c);
    e.alt_form        = hash;
    e.zero_pad        = zero;
    e.left_align      = dash;
    e.plus_sign       = plus;
    e.space_sign      = space;
    e.has_precision   = dot;
    e.field_width     = width_acc;
    e.precision_value = prec_acc;
    expected_specs.push_back(e);
    clear_parse();
  endfunction

  // one accepted request: advance the parse
  function void note_char(input fsp_pkg::in_item_t it);
    logic [7:0] c;
    int fi;
    c  = it.ch;
    fi = flag_slot(c);
    case (phase)
      fsp_pkg::PH_IDLE: begin
        if (c == fsp_pkg::CH_PCT) begin
          clear_parse();
          phase = fsp_pkg::PH_FLAGS;
        end
      end
      fsp_pkg::PH_FLAGS: begin
        if (conv_known(c)) begin
          close_spec(c, it.text_length);
        end else if (fi != NO_FLAG && c == last_flag) begin
          // adjacent repeat of a flag is swallowed
        end else if (fi != NO_FLAG && !flags[fi]) begin
          flags[fi] = 1'b1;
          last_flag = c;
        end else if (c >= fsp_pkg::CH_ONE && c <= fsp_pkg::CH_NINE) begin
          width_acc = push_digit('0, c);
          phase     = fsp_pkg::PH_WIDTH;
        end else if (c == fsp_pkg::CH_DOT) begin
          dot_seen = 1'b1;
          phase    = fsp_pkg::PH_PREC;
        end else begin
          close_spec(c, it.text_length);
        end
      end
      fsp_pkg::PH_WIDTH: begin
        if (is_num(c)) begin
          width_acc = push_digit(width_acc, c);
        end else if (c == fsp_pkg::CH_DOT) begin
          dot_seen = 1'b1;
          phase    = fsp_pkg::PH_PREC;
        end else begin
          close_spec(c, it.text_length);
        end
      end
      default: begin
        if (is_num(c)) begin
          prec_acc = push_digit(prec_acc, c);
        end else begin
          close_spec(c, it.text_length);
        end
      end
    endcase
  endfunction

  function int pending_count();
    return expected_specs.size();
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // compare one accepted result with the oldest expected specifier
  function void check_spec(input fsp_pkg::out_item_t got);
    fsp_pkg::out_item_t e;
    if (expected_specs.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing actual conv_char %0d",
               $time, got.conv_char);
      return;
    end
    e = expected_specs.pop_front();
    check_field("conv_char", 32'(e.conv_char), 32'(got.conv_char));
    check_field("conv_known", 32'(e.conv_known), 32'(got.conv_known));
    check_field("alt_form", 32'(e.alt_form), 32'(got.alt_form));
    check_field("zero_pad", 32'(e.zero_pad), 32'(got.zero_pad));
    check_field("left_align", 32'(e.left_align), 32'(got.left_align));
    check_field("plus_sign", 32'(e.plus_sign), 32'(got.plus_sign));
    check_field("space_sign", 32'(e.space_sign), 32'(got.space_sign));
    check_field("has_precision", 32'(e.has_precision), 32'(got.has_precision));
    check_field("field_width", 32'(e.field_width), 32'(got.field_width));
    check_field("precision_value", 32'(e.precision_value), 32'(got.precision_value));
  endfunction
endclass

module format_spec_parser_unit_tb;
  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  fsp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  fsp_pkg::out_item_t out_data;

  spec_checker sb;
  int          idle_pct;
  int          stall_pct;
  int          hold_left;

  format_spec_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_spec(out_data);
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [fsp_pkg::ACC_W-1:0] rand_len();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_flag(input int k);
    case (k)
      0:       return fsp_pkg::CH_HASH;
      1:       return fsp_pkg::CH_ZERO;
      2:       return fsp_pkg::CH_DASH;
      3:       return fsp_pkg::CH_PLUS;
      default: return fsp_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_conv(input int k);
    case (k)
      0:       return fsp_pkg::CH_C;
      1:       return fsp_pkg::CH_S;
      2:       return fsp_pkg::CH_P;
      3:       return fsp_pkg::CH_D;
      4:       return fsp_pkg::CH_I;
      5:       return fsp_pkg::CH_U;
      6:       return fsp_pkg::CH_LX;
      7:       return fsp_pkg::CH_UX;
      default: return fsp_pkg::CH_PCT;
    endcase
  endfunction

  // mostly small numbers, a few near and past saturation
  function automatic int unsigned pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 20);
    if (r < 90) return $urandom_range(1, 65535);
    return $urandom_range(65536, 9999999);
  endfunction

  // one request, with random idle cycles before it
  task automatic send_char(input logic [7:0] c, input logic [fsp_pkg::ACC_W-1:0] len);
    fsp_pkg::in_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.ch          = c;
    it.text_length = len;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic [fsp_pkg::ACC_W-1:0] len);
    for (int i = 0; i < s.len(); i++) send_char(s[i], len);
  endtask

  task automatic send_digits(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_char(s[i], rand_len());
  endtask

  // one random specifier, sometimes with noise ahead or a broken ending
  task automatic send_random_spec();
    int                        nflags;
    int                        k;
    logic [4:0]                used;
    int                        plimit;
    int                        t;
    logic [7:0]                term;
    logic [7:0]                fc;
    logic [fsp_pkg::ACC_W-1:0] len;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), rand_len());
    end
    send_char(fsp_pkg::CH_PCT, rand_len());

    // flags, mostly distinct, some adjacent repeats
    used   = '0;
    nflags = $urandom_range(0, 5);
    for (int i = 0; i < nflags; i++) begin
      k = $urandom_range(0, 4);
      if (used[k] && $urandom_range(0, 9) != 0) continue;
      used[k] = 1'b1;
      fc = pick_flag(k);
      send_char(fc, rand_len());
      if ($urandom_range(0, 4) == 0) send_char(fc, rand_len());
    end

    // width
    if ($urandom_range(0, 9) < 6) send_digits(pick_value());

    // precision, sometimes with leading zeros
    plimit = 0;
    if ($urandom_range(0, 9) < 4) begin
      send_char(fsp_pkg::CH_DOT, rand_len());
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) send_char(fsp_pkg::CH_ZERO, rand_len());
      end
      if ($urandom_range(0, 9) < 7) begin
        t = pick_value();
        send_digits(t);
        plimit = (t > 65535) ? 65535 : t;
      end
    end

    // conversion or a terminator that breaks the grammar
    if ($urandom_range(99) < 82) begin
      term = pick_conv($urandom_range(0, 8));
    end else begin
      case ($urandom_range(0, 5))
        0:       term = 8'h00;
        1:       term = fsp_pkg::CH_DOT;
        2:       term = fsp_pkg::CH_PLUS;
        3:       term = fsp_pkg::CH_DASH;
        4:       term = fsp_pkg::CH_SPACE;
        default: term = 8'($urandom_range(0, 255));
      endcase
    end

    // text length around the precision to hit the zero-pad rule
    case ($urandom_range(0, 4))
      0:       len = '0;
      1:       len = fsp_pkg::ACC_MAX;
      2:       len = rand_len();
      default: begin
        k = $urandom_range(0, 2);
        t = plimit + k - 1;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        len = 16'(t);
      end
    endcase
    send_char(term, len);
  endtask

  // sender holds off until the block has delivered everything
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: literal percent, all flags, zero after flags, overflow,
    // leading precision zeros with second dot, sign after dot, byte extremes
    send_text("%%", '0);
    send_text("%#0-+ d", fsp_pkg::ACC_MAX);
    send_text("%0#0", 16'd5);
    send_text("%99999x", '0);
    send_text("%.05.", 16'd6);
    send_text("%.-", 16'd1);
    send_char(fsp_pkg::CH_PCT, '0);
    send_char(8'h00, 16'd3);
    send_char(fsp_pkg::CH_PCT, fsp_pkg::ACC_MAX);
    send_char(8'hFF, fsp_pkg::ACC_MAX);
    wait_for_results();

    // random specifiers across the idling mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      repeat (12) send_random_spec();
      wait_for_results();
    end

    // back-pressure: receiver holds off while the sender keeps pushing
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (10) send_random_spec();
    wait_for_results();

    // mixed tail, then drain
    idle_pct  = 14;
    stall_pct = 14;
    repeat (10) send_random_spec();
    wait_for_results();
    repeat (4) @(posedge clk);

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
